### design/lot_pkg.sv
// Shared types and constants for the lease ownership table.
// Used by lot_ctrl, lot_dp, the top level and the port checker; no dependencies.
`timescale 1ns / 1ps
package lot_pkg;

  localparam int TABLE_ENTRIES_DEF = 16;
  localparam int MAX_RESULTS       = 16;
  localparam int CNT_W             = $clog2(MAX_RESULTS + 1);

  localparam int MODE_W     = 3;
  localparam int STATUS_W   = 2;
  localparam int KEY_W      = 16;
  localparam int OWNER_W    = 16;
  localparam int TICK_W     = 32;
  localparam int IN_DATA_W  = 104;
  localparam int OUT_DATA_W = 40;

  localparam logic [MODE_W-1:0] MODE_CLAIM   = 3'd0;
  localparam logic [MODE_W-1:0] MODE_RELEASE = 3'd1;
  localparam logic [MODE_W-1:0] MODE_CHECK   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_LIST    = 3'd3;
  localparam logic [MODE_W-1:0] MODE_CLEAR   = 3'd4;

  localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_REFUSED = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_EVAL,
    ST_FINAL
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic rd;
    logic eval;
    logic fin;
  } lot_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic walk;
    logic last_idx;
    logic push_needed;
    logic out_free;
  } lot_sts_t;

endpackage

### design/lot_ctrl.sv
// Controller state machine of the lease ownership table.
// Sequences the slot walk and the final update; depends on lot_pkg.
`timescale 1ns / 1ps
module lot_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  lot_pkg::lot_sts_t sts,
  output lot_pkg::lot_cmd_t cmd
);

  lot_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lot_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lot_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = sts.walk ? lot_pkg::ST_READ : lot_pkg::ST_FINAL;
        end
      end
      lot_pkg::ST_READ: begin
        state_nxt = lot_pkg::ST_EVAL;
      end
      lot_pkg::ST_EVAL: begin
        // hold while a listed word waits for room in the output register
        if (!sts.push_needed || sts.out_free) begin
          state_nxt = sts.last_idx ? lot_pkg::ST_FINAL : lot_pkg::ST_READ;
        end
      end
      lot_pkg::ST_FINAL: begin
        if (sts.out_free) begin
          state_nxt = lot_pkg::ST_IDLE;
        end
      end
      default: state_nxt = lot_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready = 1'b0;
    cmd       = '0;
    unique case (state_r)
      lot_pkg::ST_IDLE: begin
        // take no word while reset is held
        in_tready = rst_n;
        cmd.load  = in_tvalid && rst_n;
      end
      lot_pkg::ST_READ: begin
        cmd.rd = 1'b1;
      end
      lot_pkg::ST_EVAL: begin
        cmd.eval = !sts.push_needed || sts.out_free;
      end
      lot_pkg::ST_FINAL: begin
        cmd.fin = sts.out_free;
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

endmodule

### design/lot_dp.sv
// Datapath of the lease ownership table: slot memory, used bits, walk trackers
// and the output register. Driven by lot_ctrl; depends on lot_pkg.
`timescale 1ns / 1ps
module lot_dp #(
  parameter int TABLE_ENTRIES = lot_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [lot_pkg::IN_DATA_W-1:0]   in_tdata,
  input  logic [lot_pkg::MODE_W-1:0]      in_tuser,
  input  lot_pkg::lot_cmd_t               cmd,
  output lot_pkg::lot_sts_t               sts,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [lot_pkg::OUT_DATA_W-1:0]  out_tdata,
  output logic                            out_tuser,
  output logic                            out_tlast
);

  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TABLE_ENTRIES - 1);
  localparam logic [lot_pkg::CNT_W-1:0] CNT_MAX = lot_pkg::CNT_W'(lot_pkg::MAX_RESULTS);

  // request
  logic [lot_pkg::MODE_W-1:0]  mode_r;
  logic [lot_pkg::KEY_W-1:0]   key_r;
  logic [lot_pkg::OWNER_W-1:0] src_r;
  logic [lot_pkg::TICK_W-1:0]  lease_r;
  logic                        force_r;
  logic [lot_pkg::TICK_W-1:0]  now_r;

  // slot memory and read register
  logic [lot_pkg::KEY_W-1:0]   mem_key   [TABLE_ENTRIES];
  logic [lot_pkg::OWNER_W-1:0] mem_owner [TABLE_ENTRIES];
  logic [lot_pkg::TICK_W-1:0]  mem_lease [TABLE_ENTRIES];
  logic [lot_pkg::TICK_W-1:0]  mem_last  [TABLE_ENTRIES];
  logic [lot_pkg::KEY_W-1:0]   rd_key_r;
  logic [lot_pkg::OWNER_W-1:0] rd_owner_r;
  logic [lot_pkg::TICK_W-1:0]  rd_lease_r;
  logic [lot_pkg::TICK_W-1:0]  rd_last_r;

  logic [TABLE_ENTRIES-1:0] valid_r, valid_nxt;
  logic [IDX_W-1:0]         idx_r;

  // walk trackers
  logic                        match_r;
  logic [IDX_W-1:0]            match_idx_r;
  logic                        match_lapsed_r;
  logic [lot_pkg::OWNER_W-1:0] match_owner_r;
  logic                        free_r;
  logic [IDX_W-1:0]            free_idx_r;
  logic                        pend_r;
  logic [lot_pkg::OWNER_W-1:0] pend_owner_r;
  logic [lot_pkg::KEY_W-1:0]   pend_key_r;
  logic [lot_pkg::CNT_W-1:0]   cnt_r;

  // output register
  logic                          out_valid_r;
  logic [lot_pkg::STATUS_W-1:0]  o_status_r;
  logic                          o_known_r;
  logic [lot_pkg::OWNER_W-1:0]   o_owner_r;
  logic [lot_pkg::KEY_W-1:0]     o_key_r;
  logic                          o_entry_r;
  logic                          o_last_r;

  logic                        used, lapsed, hit, list_take, push;
  logic [lot_pkg::TICK_W-1:0]  age;

  // final decision
  logic [lot_pkg::STATUS_W-1:0] f_status;
  logic                         f_known;
  logic [lot_pkg::OWNER_W-1:0]  f_owner;
  logic [lot_pkg::KEY_W-1:0]    f_key;
  logic                         f_entry;
  logic                         f_wr, f_touch, f_clr_one, f_set_one, f_clr_all;
  logic [IDX_W-1:0]             f_idx;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r  <= in_tuser;
      key_r   <= in_tdata[15:0];
      src_r   <= in_tdata[31:16];
      lease_r <= in_tdata[63:32];
      force_r <= in_tdata[64];
      now_r   <= in_tdata[96:65];
    end
  end

  // slot under evaluation
  always_comb begin
    used      = valid_r[idx_r];
    age       = now_r - rd_last_r;
    lapsed    = (rd_lease_r != '0) && (age > rd_lease_r);
    hit       = used && (rd_key_r == key_r);
    list_take = (mode_r == lot_pkg::MODE_LIST) && used && !lapsed && (cnt_r < CNT_MAX);
  end

  assign sts.walk        = (in_tuser <= lot_pkg::MODE_LIST);
  assign sts.last_idx    = (idx_r == IDX_LAST);
  assign sts.push_needed = list_take && pend_r;
  assign sts.out_free    = !out_valid_r || out_tready;

  assign push = (cmd.eval && sts.push_needed) || cmd.fin;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= '0;
      match_r <= 1'b0;
      free_r  <= 1'b0;
      pend_r  <= 1'b0;
      cnt_r   <= '0;
    end else if (cmd.load) begin
      idx_r   <= '0;
      match_r <= 1'b0;
      free_r  <= 1'b0;
      pend_r  <= 1'b0;
      cnt_r   <= '0;
    end else if (cmd.eval) begin
      if (!sts.last_idx) begin
        idx_r <= idx_r + 1'b1;
      end
      if (hit && !match_r) begin
        match_r <= 1'b1;
      end
      if ((!used || lapsed) && !free_r) begin
        free_r <= 1'b1;
      end
      if (list_take) begin
        pend_r <= 1'b1;
        cnt_r  <= cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      if (hit && !match_r) begin
        match_idx_r    <= idx_r;
        match_lapsed_r <= lapsed;
        match_owner_r  <= rd_owner_r;
      end
      if ((!used || lapsed) && !free_r) begin
        free_idx_r <= idx_r;
      end
      if (list_take) begin
        pend_owner_r <= rd_owner_r;
        pend_key_r   <= rd_key_r;
      end
    end
  end

  always_comb begin
    f_status  = lot_pkg::STATUS_REFUSED;
    f_known   = 1'b0;
    f_owner   = '0;
    f_key     = '0;
    f_entry   = 1'b0;
    f_wr      = 1'b0;
    f_touch   = 1'b0;
    f_clr_one = 1'b0;
    f_set_one = 1'b0;
    f_clr_all = 1'b0;
    f_idx     = match_idx_r;
    unique case (mode_r)
      lot_pkg::MODE_CLAIM: begin
        if (match_r && !match_lapsed_r && !force_r && (match_owner_r != src_r)) begin
          f_known = 1'b1;
          f_owner = match_owner_r;
        end else if (match_r || free_r) begin
          f_idx     = match_r ? match_idx_r : free_idx_r;
          f_wr      = 1'b1;
          f_set_one = 1'b1;
          f_status  = lot_pkg::STATUS_OK;
          f_known   = 1'b1;
          f_owner   = src_r;
        end else begin
          f_status = lot_pkg::STATUS_FULL;
        end
      end
      lot_pkg::MODE_RELEASE, lot_pkg::MODE_CHECK: begin
        if (!match_r || match_lapsed_r) begin
          // drop an expired lease on the way
          f_clr_one = match_r;
        end else if (match_owner_r != src_r) begin
          f_known = 1'b1;
          f_owner = match_owner_r;
        end else if (mode_r == lot_pkg::MODE_RELEASE) begin
          f_clr_one = 1'b1;
          f_status  = lot_pkg::STATUS_OK;
        end else begin
          f_touch  = 1'b1;
          f_status = lot_pkg::STATUS_OK;
          f_known  = 1'b1;
          f_owner  = src_r;
        end
      end
      lot_pkg::MODE_LIST: begin
        f_status = lot_pkg::STATUS_OK;
        if (pend_r) begin
          f_known = 1'b1;
          f_owner = pend_owner_r;
          f_key   = pend_key_r;
          f_entry = 1'b1;
        end
      end
      lot_pkg::MODE_CLEAR: begin
        f_status  = lot_pkg::STATUS_OK;
        f_clr_all = 1'b1;
      end
      default: begin
        f_status = lot_pkg::STATUS_REFUSED;
      end
    endcase
  end

  always_comb begin
    valid_nxt = valid_r;
    if (cmd.eval && (mode_r == lot_pkg::MODE_LIST) && used && lapsed) begin
      valid_nxt[idx_r] = 1'b0;
    end
    if (cmd.fin) begin
      if (f_clr_all) begin
        valid_nxt = '0;
      end
      if (f_clr_one) begin
        valid_nxt[f_idx] = 1'b0;
      end
      if (f_set_one) begin
        valid_nxt[f_idx] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fin && f_wr) begin
      mem_key[f_idx]   <= key_r;
      mem_owner[f_idx] <= src_r;
      mem_lease[f_idx] <= lease_r;
    end
    if (cmd.fin && (f_wr || f_touch)) begin
      mem_last[f_idx] <= now_r;
    end
    if (cmd.rd) begin
      rd_key_r   <= mem_key[idx_r];
      rd_owner_r <= mem_owner[idx_r];
      rd_lease_r <= mem_lease[idx_r];
      rd_last_r  <= mem_last[idx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (push) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      if (cmd.fin) begin
        o_status_r <= f_status;
        o_known_r  <= f_known;
        o_owner_r  <= f_owner;
        o_key_r    <= f_key;
        o_entry_r  <= f_entry;
        o_last_r   <= 1'b1;
      end else begin
        // a later live lease was found: the held one is not the last word
        o_status_r <= lot_pkg::STATUS_OK;
        o_known_r  <= 1'b1;
        o_owner_r  <= pend_owner_r;
        o_key_r    <= pend_key_r;
        o_entry_r  <= 1'b1;
        o_last_r   <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b0, o_key_r, o_owner_r, o_known_r, o_status_r};
  assign out_tuser  = o_entry_r;
  assign out_tlast  = o_last_r;

endmodule

### design/lease_ownership_table.sv
// Lease ownership table: a keyed table of owner leases with expiry by tick count.
// Top level; joins lot_ctrl and lot_dp, depends on lot_pkg.
//
// Input channel in_*: one request word per handshake, mode in in_tuser.
// Result channel out_*: one or more words per request, out_tlast on the final one.
// Claim, release, check and list requests walk the slot memory one slot at a time;
// each slot passes a read state and an evaluate state, as the memory has a single
// registered read port. Clear and unknown modes skip the walk and go straight to
// the final update. One request is in flight at a time: in_tready rises again in
// the cycle after the final word is loaded, so no new request is taken until the
// previous one has loaded its final word.
// A list request emits one word per live lease, up to 16, in slot order, and
// prunes expired leases as it goes; with none live it emits a single empty word.
// Results sit in an output register; while the receiver stalls, a list walk holds
// at the next live lease and the final update waits for room in the register.
// Reset marks every slot unused and empties the output register; slot contents
// are not cleared.
`timescale 1ns / 1ps
module lease_ownership_table #(
  parameter int TABLE_ENTRIES = lot_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // key[15:0], source_id[31:16], lease_ticks[63:32], force_req[64], now[96:65]
  input  logic [lot_pkg::IN_DATA_W-1:0]  in_tdata,
  // mode[2:0]
  input  logic [lot_pkg::MODE_W-1:0]     in_tuser,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // status[1:0], owner_known[2], current_owner[18:3], entry_key[34:19]
  output logic [lot_pkg::OUT_DATA_W-1:0] out_tdata,
  // entry_valid[0]
  output logic                           out_tuser,
  output logic                           out_tlast
);

  lot_pkg::lot_cmd_t cmd;
  lot_pkg::lot_sts_t sts;

  lot_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  lot_dp #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cmd        (cmd),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

### design/lot_checker.sv
// Port-level checks for the lease ownership table, bound to the top level.
// Sees only the top-level ports; depends on lot_pkg.
`timescale 1ns / 1ps
module lot_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_tvalid,
  input logic                           in_tready,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [lot_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic                           out_tuser
);

  // a stalled result word stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result word dropped while stalled");

  // reset empties the output register
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result word offered after reset");

  // one request at a time: ready drops after an accept
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second request taken while one is in flight");

  // no owner reported means a zero owner field
  a_owner_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[2] |-> (out_tdata[18:3] == '0))
    else $error("owner field set without owner_known");

  // a listed lease is always ok with a known owner, and only with a known owner
  a_list_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> (out_tdata[1:0] == lot_pkg::STATUS_OK) && out_tdata[2])
    else $error("listed lease word with bad status or owner flag");

endmodule

bind lease_ownership_table lot_checker u_lot_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

### tb/lease_ownership_table_check.sv
// Scoreboard for the lease ownership table: watches both streams, predicts every result word.
// Holds its own copy of the lease slots; depends on lot_pkg for field widths and mode codes.
`timescale 1ns / 1ps
module lease_ownership_table_check #(
  parameter int ENTRIES = lot_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  input  logic                           in_tready,
  // key[15:0], source_id[31:16], lease_ticks[63:32], force_req[64], now[96:65]
  input  logic [lot_pkg::IN_DATA_W-1:0]  in_tdata,
  // mode[2:0]
  input  logic [lot_pkg::MODE_W-1:0]     in_tuser,
  input  logic                           out_tvalid,
  input  logic                           out_tready,
  // status[1:0], owner_known[2], current_owner[18:3], entry_key[34:19]
  input  logic [lot_pkg::OUT_DATA_W-1:0] out_tdata,
  // entry_valid[0]
  input  logic                           out_tuser,
  input  logic                           out_tlast,
  output int unsigned                    fail_count
);

  typedef struct packed {
    logic [lot_pkg::STATUS_W-1:0] status;
    logic                         known;
    logic [lot_pkg::OWNER_W-1:0]  owner;
    logic [lot_pkg::KEY_W-1:0]    entry_key;
    logic                         entry_valid;
    logic                         last;
  } lease_word_t;

  logic                         slot_used        [ENTRIES];
  logic [lot_pkg::KEY_W-1:0]    slot_key         [ENTRIES];
  logic [lot_pkg::OWNER_W-1:0]  slot_owner       [ENTRIES];
  logic [lot_pkg::TICK_W-1:0]   slot_lease       [ENTRIES];
  logic [lot_pkg::TICK_W-1:0]   slot_last_active [ENTRIES];

  lease_word_t owed_words [$];
  lease_word_t seen, want;
  int unsigned mismatches = 0;
  int unsigned owed_count = 0;

  assign fail_count = mismatches + owed_count;

  function automatic logic lease_lapsed(int s, logic [lot_pkg::TICK_W-1:0] now);
    logic [lot_pkg::TICK_W-1:0] age;
    age = now - slot_last_active[s];
    return (slot_lease[s] != '0) && (age > slot_lease[s]);
  endfunction

  task automatic owe_word(input logic [lot_pkg::STATUS_W-1:0] status, input logic known,
                          input logic [lot_pkg::OWNER_W-1:0] owner,
                          input logic [lot_pkg::KEY_W-1:0] ekey,
                          input logic valid, input logic fin);
    lease_word_t w;
    w = {status, known, owner, ekey, valid, fin};
    owed_words.push_back(w);
  endtask

  task automatic predict_request(input logic [lot_pkg::MODE_W-1:0] mode,
                                 input logic [lot_pkg::KEY_W-1:0] key,
                                 input logic [lot_pkg::OWNER_W-1:0] src,
                                 input logic [lot_pkg::TICK_W-1:0] lease,
                                 input logic frc, input logic [lot_pkg::TICK_W-1:0] now);
    int s;
    int hit;
    int spot;
    int live;
    int listed;
    hit = -1;
    for (s = 0; s < ENTRIES; s++)
      if (hit < 0 && slot_used[s] && slot_key[s] == key) hit = s;
    case (mode)
      lot_pkg::MODE_CLAIM: begin
        if (hit >= 0 && !lease_lapsed(hit, now) && !frc && slot_owner[hit] != src) begin
          owe_word(lot_pkg::STATUS_REFUSED, 1'b1, slot_owner[hit], '0, 1'b0, 1'b1);
        end else begin
          spot = hit;
          // a new key takes the lowest free or lapsed slot
          for (s = 0; s < ENTRIES; s++)
            if (spot < 0 && (!slot_used[s] || lease_lapsed(s, now))) spot = s;
          if (spot < 0) begin
            owe_word(lot_pkg::STATUS_FULL, 1'b0, '0, '0, 1'b0, 1'b1);
          end else begin
            slot_used[spot]        = 1'b1;
            slot_key[spot]         = key;
            slot_owner[spot]       = src;
            slot_lease[spot]       = lease;
            slot_last_active[spot] = now;
            owe_word(lot_pkg::STATUS_OK, 1'b1, src, '0, 1'b0, 1'b1);
          end
        end
      end
      lot_pkg::MODE_RELEASE, lot_pkg::MODE_CHECK: begin
        if (hit >= 0 && lease_lapsed(hit, now)) begin
          slot_used[hit] = 1'b0;
          hit = -1;
        end
        if (hit < 0) begin
          owe_word(lot_pkg::STATUS_REFUSED, 1'b0, '0, '0, 1'b0, 1'b1);
        end else if (slot_owner[hit] != src) begin
          owe_word(lot_pkg::STATUS_REFUSED, 1'b1, slot_owner[hit], '0, 1'b0, 1'b1);
        end else if (mode == lot_pkg::MODE_RELEASE) begin
          slot_used[hit] = 1'b0;
          owe_word(lot_pkg::STATUS_OK, 1'b0, '0, '0, 1'b0, 1'b1);
        end else begin
          slot_last_active[hit] = now;
          owe_word(lot_pkg::STATUS_OK, 1'b1, src, '0, 1'b0, 1'b1);
        end
      end
      lot_pkg::MODE_LIST: begin
        // prune first, then list the survivors so the final word can be marked
        live = 0;
        for (s = 0; s < ENTRIES; s++)
          if (slot_used[s]) begin
            if (lease_lapsed(s, now)) slot_used[s] = 1'b0;
            else live++;
          end
        if (live > lot_pkg::MAX_RESULTS) live = lot_pkg::MAX_RESULTS;
        if (live == 0) begin
          owe_word(lot_pkg::STATUS_OK, 1'b0, '0, '0, 1'b0, 1'b1);
        end else begin
          listed = 0;
          for (s = 0; s < ENTRIES; s++)
            if (slot_used[s] && listed < live) begin
              listed++;
              owe_word(lot_pkg::STATUS_OK, 1'b1, slot_owner[s], slot_key[s], 1'b1,
                       listed == live);
            end
        end
      end
      lot_pkg::MODE_CLEAR: begin
        for (s = 0; s < ENTRIES; s++) slot_used[s] = 1'b0;
        owe_word(lot_pkg::STATUS_OK, 1'b0, '0, '0, 1'b0, 1'b1);
      end
      default: owe_word(lot_pkg::STATUS_REFUSED, 1'b0, '0, '0, 1'b0, 1'b1);
    endcase
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < ENTRIES; s++) slot_used[s] = 1'b0;
    end else begin
      if (in_tvalid && in_tready)
        predict_request(in_tuser, in_tdata[15:0], in_tdata[31:16], in_tdata[63:32],
                        in_tdata[64], in_tdata[96:65]);
      if (out_tvalid && out_tready) begin
        seen = {out_tdata[1:0], out_tdata[2], out_tdata[18:3], out_tdata[34:19],
                out_tuser, out_tlast};
        if (owed_words.size() == 0) begin
          $display("%0t: unexpected word, expected none, got %p", $time, seen);
          mismatches++;
        end else begin
          want = owed_words.pop_front();
          if (seen !== want) begin
            $display("%0t: word mismatch, expected %p, got %p", $time, want, seen);
            mismatches++;
          end
        end
      end
    end
    owed_count = owed_words.size();
  end

endmodule

### tb/lease_ownership_table_test.sv
// Top of the lease ownership table test: clock, reset, request stimulus and verdict.
// Instantiates the block and lease_ownership_table_check; depends on lot_pkg.
`timescale 1ns / 1ps
module lease_ownership_table_test;

  localparam logic [lot_pkg::MODE_W-1:0] MODE_SPARE_A = 3'd5;
  localparam logic [lot_pkg::MODE_W-1:0] MODE_SPARE_B = 3'd6;
  localparam logic [lot_pkg::MODE_W-1:0] MODE_SPARE_C = 3'd7;

  logic                           clk        = 1'b0;
  logic                           rst_n      = 1'b0;
  logic                           in_tvalid  = 1'b0;
  logic                           in_tready;
  logic [lot_pkg::IN_DATA_W-1:0]  in_tdata   = '0;
  logic [lot_pkg::MODE_W-1:0]     in_tuser   = '0;
  logic                           out_tvalid;
  logic                           out_tready = 1'b0;
  logic [lot_pkg::OUT_DATA_W-1:0] out_tdata;
  logic                           out_tuser;
  logic                           out_tlast;
  int unsigned                    fail_count;

  int unsigned requests_sent    = 0;
  int unsigned requests_settled = 0;
  bit          calm             = 1'b0;
  bit          rx_hold_req      = 1'b0;

  logic [lot_pkg::KEY_W-1:0]   held_key [8];
  logic [lot_pkg::OWNER_W-1:0] held_src [8];
  int unsigned                 held_wr = 0;
  logic [lot_pkg::TICK_W-1:0]  clock_now = '0;

  lease_ownership_table u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast)
  );

  lease_ownership_table_check u_check (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast), .fail_count(fail_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // one request is settled when its final word goes out
  always @(posedge clk)
    if (rst_n && out_tvalid && out_tready && out_tlast) requests_settled <= requests_settled + 1;

  function automatic int unsigned idle_len(int unsigned lo);
    int unsigned pick;
    pick = $urandom_range(0, 19);
    if (pick < 12) return lo;
    if (pick < 18) return lo + $urandom_range(1, 3);
    return $urandom_range(15, 60);
  endfunction

  function automatic logic [lot_pkg::KEY_W-1:0] pool_key();
    int unsigned idx;
    idx = $urandom_range(0, 23);
    return (idx == 23) ? 16'hFFFF : 16'(idx);
  endfunction

  function automatic logic [lot_pkg::OWNER_W-1:0] pool_src();
    return ($urandom_range(0, 9) == 0) ? 16'hFFFF : 16'($urandom_range(0, 3));
  endfunction

  function automatic logic [lot_pkg::TICK_W-1:0] pool_lease();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick < 4) return '0;
    if (pick < 8) return 32'($urandom_range(1, 60));
    if (pick < 9) return $urandom;
    return 32'hFFFF_FFFF;
  endfunction

  task automatic offer_request(input logic [lot_pkg::MODE_W-1:0] mode,
                               input logic [lot_pkg::KEY_W-1:0] key,
                               input logic [lot_pkg::OWNER_W-1:0] src,
                               input logic [lot_pkg::TICK_W-1:0] lease,
                               input logic frc, input logic [lot_pkg::TICK_W-1:0] now);
    int unsigned gap;
    in_tuser  <= mode;
    in_tdata  <= {7'd0, now, frc, lease, src, key};
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    requests_sent++;
    gap = calm ? 0 : idle_len(0);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // hold the sender until every request has had its final word
  task automatic drain_requests();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (requests_settled != requests_sent) @(posedge clk);
  endtask

  initial begin
    forever begin
      if (rx_hold_req) begin
        out_tready <= 1'b0;
        repeat (300) @(posedge clk);
        rx_hold_req = 1'b0;
      end else begin
        out_tready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
        if (!calm) begin
          out_tready <= 1'b0;
          repeat (idle_len(1)) @(posedge clk);
        end
      end
    end
  end

  initial begin
    int unsigned phase;
    int unsigned n;
    int unsigned pick;
    int unsigned k;
    logic [lot_pkg::MODE_W-1:0]  mode;
    logic [lot_pkg::KEY_W-1:0]   key;
    logic [lot_pkg::OWNER_W-1:0] src;
    logic [lot_pkg::TICK_W-1:0]  lease;
    logic                        frc;

    for (k = 0; k < 8; k++) begin
      held_key[k] = '0;
      held_src[k] = '0;
    end
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty list, extremes, steal, expiry, wrap, spare modes
    offer_request(lot_pkg::MODE_LIST,    16'h0000, 16'h0000, 32'h0,         1'b0, 32'h0);
    offer_request(lot_pkg::MODE_CLAIM,   16'h0000, 16'h0000, 32'h0,         1'b0, 32'h0);
    offer_request(lot_pkg::MODE_CLAIM,   16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 1'b0, 32'h5);
    offer_request(lot_pkg::MODE_CLAIM,   16'h0000, 16'h0001, 32'h0,         1'b0, 32'h6);
    offer_request(lot_pkg::MODE_CLAIM,   16'h0000, 16'h0001, 32'h0,         1'b1, 32'h7);
    offer_request(lot_pkg::MODE_CHECK,   16'h0000, 16'h0000, 32'h0,         1'b0, 32'h8);
    offer_request(lot_pkg::MODE_CHECK,   16'h0000, 16'h0001, 32'h0,         1'b0, 32'd100);
    offer_request(lot_pkg::MODE_CLAIM,   16'h000A, 16'h0002, 32'd10,        1'b0, 32'd100);
    offer_request(lot_pkg::MODE_CHECK,   16'h000A, 16'h0002, 32'h0,         1'b0, 32'd111);
    offer_request(lot_pkg::MODE_CLAIM,   16'h000B, 16'h0003, 32'd5,         1'b0, 32'd200);
    offer_request(lot_pkg::MODE_RELEASE, 16'h000B, 16'h0004, 32'h0,         1'b0, 32'd205);
    offer_request(lot_pkg::MODE_RELEASE, 16'h000B, 16'h0003, 32'h0,         1'b0, 32'd205);
    offer_request(lot_pkg::MODE_RELEASE, 16'h000B, 16'h0003, 32'h0,         1'b0, 32'd206);
    offer_request(lot_pkg::MODE_CLAIM,   16'h000C, 16'h0003, 32'd1,         1'b0, 32'd300);
    offer_request(lot_pkg::MODE_RELEASE, 16'h000C, 16'h0003, 32'h0,         1'b0, 32'd302);
    offer_request(lot_pkg::MODE_CLAIM,   16'hFFFF, 16'hFFFF, 32'd7,         1'b0, 32'd400);
    offer_request(lot_pkg::MODE_CLAIM,   16'h0014, 16'h0002, 32'd100,       1'b0, 32'hFFFF_FFF0);
    offer_request(lot_pkg::MODE_LIST,    16'h0000, 16'h0000, 32'h0,         1'b0, 32'h20);
    offer_request(lot_pkg::MODE_CHECK,   16'h0014, 16'h0002, 32'h0,         1'b0, 32'h60);
    offer_request(lot_pkg::MODE_CLAIM,   16'h0015, 16'hFFFF, 32'h0,         1'b1, 32'hFFFF_FFFF);
    offer_request(MODE_SPARE_A,          16'h0015, 16'hFFFF, 32'h0,         1'b0, 32'h61);
    offer_request(MODE_SPARE_B,          16'h0000, 16'h0000, 32'h0,         1'b0, 32'h62);
    offer_request(MODE_SPARE_C,          16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 1'b1, 32'h63);
    offer_request(lot_pkg::MODE_LIST,    16'h0000, 16'h0000, 32'h0,         1'b0, 32'h64);
    drain_requests();

    // fill the table: the first lease lapses and is reused, then the table is full
    offer_request(lot_pkg::MODE_CLEAR, 16'h0000, 16'h0000, 32'h0, 1'b0, 32'd1000);
    offer_request(lot_pkg::MODE_CLAIM, 16'd100, 16'h0005, 32'd4, 1'b0, 32'd1000);
    for (k = 1; k < 16; k++)
      offer_request(lot_pkg::MODE_CLAIM, 16'(100 + k), 16'h0005, 32'h0, 1'b0, 32'd1001);
    offer_request(lot_pkg::MODE_CLAIM, 16'd116, 16'h0006, 32'h0, 1'b0, 32'd1010);
    offer_request(lot_pkg::MODE_CLAIM, 16'd117, 16'h0006, 32'h0, 1'b0, 32'd1011);
    offer_request(lot_pkg::MODE_LIST,  16'h0000, 16'h0000, 32'h0, 1'b0, 32'd1012);
    offer_request(lot_pkg::MODE_CLEAR, 16'h0000, 16'h0000, 32'h0, 1'b0, 32'd1013);
    drain_requests();

    clock_now = 32'd2000;
    for (phase = 0; phase < 6; phase++) begin
      calm = (phase == 2);
      if (phase == 3) rx_hold_req = 1'b1;
      for (n = 0; n < 48; n++) begin
        if ($urandom_range(0, 49) == 0) clock_now = $urandom;
        else clock_now = clock_now + 32'($urandom_range(0, 12));
        key   = pool_key();
        src   = pool_src();
        lease = pool_lease();
        frc   = ($urandom_range(0, 4) == 0);
        pick  = $urandom_range(0, 99);
        if (pick < 40) begin
          mode = lot_pkg::MODE_CLAIM;
          held_key[held_wr] = key;
          held_src[held_wr] = src;
          held_wr = (held_wr + 1) % 8;
        end else if (pick < 75) begin
          mode = (pick < 60) ? lot_pkg::MODE_CHECK : lot_pkg::MODE_RELEASE;
          // mostly act on a lease that was recently claimed, by its claimant
          if ($urandom_range(0, 3) != 0) begin
            k   = $urandom_range(0, 7);
            key = held_key[k];
            src = held_src[k];
          end
        end else if (pick < 88) begin
          mode = lot_pkg::MODE_LIST;
        end else if (pick < 91) begin
          mode = lot_pkg::MODE_CLEAR;
        end else if (pick < 94) begin
          mode = 3'($urandom_range(MODE_SPARE_A, MODE_SPARE_C));
        end else begin
          mode  = 3'($urandom_range(lot_pkg::MODE_CLAIM, lot_pkg::MODE_CHECK));
          key   = 16'($urandom_range(0, 65535));
          src   = 16'($urandom_range(0, 65535));
          lease = $urandom;
        end
        offer_request(mode, key, src, lease, frc, clock_now);
      end
      drain_requests();
    end
    calm = 1'b0;

    repeat (40) @(posedge clk);
    if (fail_count == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

  initial begin
    #50_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

### lease_ownership_table.f
design/lot_pkg.sv
design/lot_ctrl.sv
design/lot_dp.sv
design/lease_ownership_table.sv
design/lot_checker.sv
tb/lease_ownership_table_check.sv
tb/lease_ownership_table_test.sv
